FILE: design/twtm_pkg.sv
// Shared types and constants for the timing wheel timer manager.
package twtm_pkg;
    localparam int WHEEL_SLOTS = 8192;
    localparam int NUM_TIMERS  = 32;
    localparam int POS_W = $clog2(WHEEL_SLOTS);
    localparam int KEY_W = 5;
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_STOP   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [1:0] KIND_STOP     = 2'd2;
    localparam logic [1:0] KIND_EXPIRED  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [12:0] period;
        logic        repeat_req;
        logic [4:0]  key;
        logic [31:0] user_tag;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);
endpackage

FILE: design/twtm_front.sv
// Front end: takes input words, drops unused codes, and queues commands.
module twtm_front
    import twtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  cmd_t        in_cmd,
    output logic        q_valid,
    input  logic        q_pop,
    output cmd_t        q_cmd
);
    // Two-entry queue decouples acceptance from execution.
    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall && (in_cmd.operation != OP_UNUSED);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: design/twtm_back.sv
// Back end: slot pool, wheel position, and the per-slot scan sequencer.
module twtm_back
    import twtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        q_valid,
    output logic        q_pop,
    input  cmd_t        q_cmd,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [4:0]  key_res,
    output logic        was_active,
    output logic [31:0] user_tag_res,
    output logic        last
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FIND = 5'b00010,
        S_SCAN = 5'b00100,
        S_EMIT = 5'b01000,
        S_RESP = 5'b10000
    } state_t;

    state_t state_reg;
    logic        enabled_reg;
    logic [NUM_TIMERS-1:0] active_reg;
    logic [POS_W-1:0] spos_reg [NUM_TIMERS];
    logic [12:0]      sper_reg [NUM_TIMERS];
    logic             srep_reg [NUM_TIMERS];
    logic [31:0]      stag_reg [NUM_TIMERS];
    logic [POS_W-1:0] wheel_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [NUM_TIMERS-1:0] hit_reg;
    cmd_t        cmd_reg;

    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] next_pos;
    logic [NUM_TIMERS-1:0] later_mask;
    logic             is_last;

    assign idx      = idx_reg[IDX_W-1:0];
    assign next_pos = wheel_reg + POS_W'(1);
    assign q_pop    = (state_reg == S_IDLE) && q_valid && !cfg_we;

    always_comb
    begin
        later_mask = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            later_mask[i] = (i > int'(idx));
        end
    end
    assign is_last = ((hit_reg & later_mask) == '0);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIND && !active_reg[idx] && idx_reg < CNT_W'(NUM_TIMERS)
            && enabled_reg)
        begin
            spos_reg[idx] <= wheel_reg + POS_W'(cmd_reg.period);
            sper_reg[idx] <= cmd_reg.period;
            srep_reg[idx] <= cmd_reg.repeat_req;
            stag_reg[idx] <= cmd_reg.user_tag;
        end
        if (state_reg == S_EMIT && hit_reg[idx] && (!out_valid || !out_stall)
            && srep_reg[idx])
        begin
            spos_reg[idx] <= next_pos + POS_W'(sper_reg[idx]);
        end
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            enabled_reg  <= 1'b0;
            active_reg   <= '0;
            wheel_reg    <= '0;
            idx_reg      <= '0;
            hit_reg      <= '0;
            out_valid    <= 1'b0;
            kind         <= KIND_ADD_OK;
            key_res      <= '0;
            was_active   <= 1'b0;
            user_tag_res <= '0;
            last         <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (cfg_we)
            begin
                enabled_reg <= cfg_wdata;
                if (!cfg_wdata)
                begin
                    active_reg <= '0;
                    wheel_reg  <= '0;
                end
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    hit_reg <= '0;
                    if (q_pop)
                    begin
                        unique case (q_cmd.operation)
                            OP_TICK: state_reg <= enabled_reg ? S_SCAN : S_IDLE;
                            OP_ADD:  state_reg <= S_FIND;
                            default: state_reg <= S_RESP;
                        endcase
                    end
                end
                S_FIND:
                begin
                    // The result fields are loaded only once a waiting word has left.
                    if (!enabled_reg || idx_reg == CNT_W'(NUM_TIMERS))
                    begin
                        if (!out_valid || !out_stall)
                        begin
                            kind      <= KIND_ADD_FULL;
                            key_res   <= '0;
                            state_reg <= S_RESP;
                        end
                    end
                    else if (!active_reg[idx])
                    begin
                        if (!out_valid || !out_stall)
                        begin
                            active_reg[idx] <= 1'b1;
                            kind      <= KIND_ADD_OK;
                            key_res   <= KEY_W'(idx);
                            state_reg <= S_RESP;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_SCAN:
                begin
                    // One slot a cycle builds the hit mask for this position.
                    if (idx_reg == CNT_W'(NUM_TIMERS))
                    begin
                        idx_reg <= '0;
                        if (hit_reg == '0)
                        begin
                            wheel_reg <= next_pos;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                    else
                    begin
                        hit_reg[idx] <= active_reg[idx] && (spos_reg[idx] == wheel_reg);
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                end
                S_EMIT:
                begin
                    if (!hit_reg[idx])
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    else if (!out_valid || !out_stall)
                    begin
                        out_valid    <= 1'b1;
                        kind         <= KIND_EXPIRED;
                        key_res      <= KEY_W'(idx);
                        was_active   <= 1'b0;
                        user_tag_res <= stag_reg[idx];
                        last         <= is_last;
                        hit_reg[idx] <= 1'b0;
                        if (!srep_reg[idx])
                        begin
                            active_reg[idx] <= 1'b0;
                        end
                        idx_reg <= idx_reg + CNT_W'(1);
                        if (is_last)
                        begin
                            wheel_reg <= next_pos;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_RESP:
                begin
                    if (!out_valid || !out_stall)
                    begin
                        out_valid    <= 1'b1;
                        user_tag_res <= '0;
                        last         <= 1'b0;
                        was_active   <= 1'b0;
                        if (cmd_reg.operation == OP_STOP)
                        begin
                            kind    <= KIND_STOP;
                            key_res <= cmd_reg.key;
                            if (int'(cmd_reg.key) < NUM_TIMERS &&
                                active_reg[cmd_reg.key[IDX_W-1:0]])
                            begin
                                was_active <= 1'b1;
                                active_reg[cmd_reg.key[IDX_W-1:0]] <= 1'b0;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/timing_wheel_timer_manager_top.sv
// Top level of the timing wheel timer manager.
// The back end takes one word at a time: an add walks past busy slots to the first free one,
// and a tick scans all 32 slots to build its hit mask before it emits expiries in key order.
// A two-word queue lets the front keep accepting while a result waits.
// Reset (rst_n, asynchronous, low) disables the wheel, frees all slots, sets position 0.
module timing_wheel_timer_manager_top
    import twtm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [12:0] period,
    input  logic        repeat_req,
    input  logic [4:0]  key,
    input  logic [31:0] user_tag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [4:0]  key_res,
    output logic        was_active,
    output logic [31:0] user_tag_res,
    output logic        last
);
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_pop;

    // Pack the input word fields into one command.
    assign in_cmd = '{operation: operation, period: period, repeat_req: repeat_req,
                      key: key, user_tag: user_tag};

    twtm_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    twtm_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .key_res(key_res), .was_active(was_active),
        .user_tag_res(user_tag_res), .last(last)
    );
endmodule

FILE: design/twtm_checker.sv
// Port-level checks for the timer manager, bound to the top level.
module twtm_checker
    import twtm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic        was_active,
    input logic [31:0] user_tag_res,
    input logic        last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
        else $error("stalled result changed");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind == KIND_EXPIRED)
        else $error("last on non-expiry");
    a_was: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_active |-> kind == KIND_STOP)
        else $error("was_active on non-stop");
    a_tag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_EXPIRED |-> user_tag_res == '0)
        else $error("tag on non-expiry");
endmodule

bind timing_wheel_timer_manager_top twtm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .was_active(was_active), .user_tag_res(user_tag_res), .last(last)
);

FILE: sim/tb_timing_wheel_timer_manager_top.sv
// Testbench for the timing wheel timer manager: directed table, random traffic, predictor checks.
`timescale 1ns / 1ps

module tb_timing_wheel_timer_manager_top;
    import twtm_pkg::*;

    // One result word as the block reports it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  key_res;
        logic        was_active;
        logic [31:0] user_tag_res;
        logic        last;
    } result_t;

    // A row of the directed table. When has_exp is set, the first result that the
    // row causes is also compared against the typed-in value.
    typedef struct {
        cmd_t    cmd;
        bit      has_exp;
        result_t exp;
    } row_t;

    // The wait after the last result before a register write. A tick with no
    // expiry produces nothing, yet the back end still scans every slot, and up
    // to three such ticks can be in flight.
    localparam int DRAIN_CYCLES = 120;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [12:0] period;
    logic        repeat_req;
    logic [4:0]  key;
    logic [31:0] user_tag;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [4:0]  key_res;
    logic        was_active;
    logic [31:0] user_tag_res;
    logic        last;

    // The predictor keeps its own picture of the timer pool and the wheel.
    bit               wheel_on;
    bit               slot_busy [NUM_TIMERS];
    logic [POS_W-1:0] slot_due [NUM_TIMERS];
    logic [12:0]      slot_interval [NUM_TIMERS];
    bit               slot_rearm [NUM_TIMERS];
    logic [31:0]      slot_cookie [NUM_TIMERS];
    logic [POS_W-1:0] wheel_now;

    result_t pending_results[$];
    result_t typed_results[$];
    int      mismatches;
    bit      long_hold;

    // Typed-in value for the first result of the word being sent, if any.
    bit      row_has_exp;
    result_t row_exp;
    result_t dont_care;

    timing_wheel_timer_manager_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .period       (period),
        .repeat_req   (repeat_req),
        .key          (key),
        .user_tag     (user_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .key_res      (key_res),
        .was_active   (was_active),
        .user_tag_res (user_tag_res),
        .last         (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Register write as seen by the predictor: turning the wheel off drops every
    // timer and rewinds the wheel to position zero.
    function automatic void apply_enable(bit value);
        wheel_on = value;
        if (!value)
        begin
            foreach (slot_busy[i]) slot_busy[i] = 0;
            wheel_now = '0;
        end
    endfunction

    function automatic result_t make_result(logic [1:0] k, int idx, bit act,
                                            logic [31:0] tag, bit fin);
        result_t r;
        r.kind = k;
        r.key_res = idx[4:0];
        r.was_active = act;
        r.user_tag_res = tag;
        r.last = fin;
        return r;
    endfunction

    // Queues one predicted result, paired with its typed-in value or a don't-care.
    function automatic void push_result(result_t r);
        pending_results.push_back(r);
        typed_results.push_back(row_has_exp ? row_exp : dont_care);
        row_has_exp = 1'b0;
    endfunction

    // Works out what one accepted command word produces and queues it.
    function automatic void predict_timer_results(cmd_t c);
        int last_hit;
        int free_slot;
        logic [POS_W-1:0] next_pos;
        case (c.operation)
            OP_TICK:
            begin
                if (wheel_on)
                begin
                    last_hit = -1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (slot_busy[i] && slot_due[i] == wheel_now) last_hit = i;
                    next_pos = wheel_now + 1'b1;
                    for (int i = 0; i <= last_hit; i++)
                    begin
                        if (slot_busy[i] && slot_due[i] == wheel_now)
                        begin
                            push_result(make_result(KIND_EXPIRED, i, 1'b0,
                                slot_cookie[i], i == last_hit));
                            // Repeating timers are re-filed from the advanced position.
                            if (slot_rearm[i]) slot_due[i] = next_pos + slot_interval[i];
                            else slot_busy[i] = 0;
                        end
                    end
                    wheel_now = next_pos;
                end
            end
            OP_ADD:
            begin
                free_slot = -1;
                if (wheel_on)
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (!slot_busy[i] && free_slot < 0) free_slot = i;
                if (free_slot < 0)
                    push_result(make_result(KIND_ADD_FULL, 0, 1'b0, '0, 1'b0));
                else
                begin
                    slot_busy[free_slot] = 1;
                    slot_interval[free_slot] = c.period;
                    slot_rearm[free_slot] = c.repeat_req;
                    slot_cookie[free_slot] = c.user_tag;
                    slot_due[free_slot] = wheel_now + c.period;
                    push_result(make_result(KIND_ADD_OK, free_slot, 1'b0, '0, 1'b0));
                end
            end
            OP_STOP:
            begin
                if (c.key < NUM_TIMERS && slot_busy[c.key])
                begin
                    slot_busy[c.key] = 0;
                    push_result(make_result(KIND_STOP, int'(c.key), 1'b1, '0, 1'b0));
                end
                else
                    push_result(make_result(KIND_STOP, int'(c.key), 1'b0, '0, 1'b0));
            end
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(string what, result_t exp, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t mismatch (%s): expected kind=%0d key=%0d act=%0d tag=%h ",
                      "last=%0d, got kind=%0d key=%0d act=%0d tag=%h last=%0d"},
                     $realtime, what, exp.kind, exp.key_res, exp.was_active, exp.user_tag_res,
                     exp.last, got.kind, got.key_res, got.was_active, got.user_tag_res,
                     got.last);
    endfunction

    // Sends one command word: a randomly drawn idle gap, then valid is held until
    // the block takes the word. Prediction happens at acceptance. Valid stays
    // high afterwards so that a word with no gap follows at once; the caller
    // drops it when sending pauses.
    task automatic send_word(cmd_t c);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= c.operation;
        period     <= c.period;
        repeat_req <= c.repeat_req;
        key        <= c.key;
        user_tag   <= c.user_tag;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_timer_results(c);
    endtask

    // Register writes happen only with the block idle: all results in, plus a drain.
    task automatic write_enable(bit value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_enable(value);
    endtask

    function automatic cmd_t make_cmd(logic [1:0] op, logic [12:0] per, bit rep,
                                      logic [4:0] k, logic [31:0] tag);
        cmd_t c;
        c.operation = op;
        c.period = per;
        c.repeat_req = rep;
        c.key = k;
        c.user_tag = tag;
        return c;
    endfunction

    // Random command that mostly uses short periods, so
    // expiries and re-arms actually show up; a few carry full-range fields.
    function automatic cmd_t random_cmd();
        int pick;
        logic [12:0] per;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) per = 13'($urandom_range(0, 8191));
        else per = 13'($urandom_range(0, 4));
        if (pick < 40)
            return make_cmd(OP_TICK, 13'($urandom), 1'($urandom), 5'($urandom), $urandom);
        if (pick < 80)
            return make_cmd(OP_ADD, per, 1'($urandom), 5'($urandom), $urandom);
        if (pick < 97)
            return make_cmd(OP_STOP, 13'($urandom), 1'($urandom), 5'($urandom), $urandom);
        return make_cmd(OP_UNUSED, 13'($urandom), 1'($urandom), 5'($urandom), $urandom);
    endfunction

    // Output side: random stall per word, and once a long hold so the block backs up.
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Checker: every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        result_t got;
        result_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {kind, key_res, was_active, user_tag_res, last};
            if (pending_results.size() == 0)
                report_mismatch("unexpected", '0, got);
            else
            begin
                exp = pending_results.pop_front();
                if (got !== exp) report_mismatch("predicted", exp, got);
                if (typed_results.size() != 0)
                begin
                    exp = typed_results.pop_front();
                    if (exp !== dont_care)
                        if (got !== exp) report_mismatch("table", exp, got);
                end
            end
        end
    end

    // Directed table: an add reported full while disabled, stops of free and busy
    // slots, zero and maximum period, repeat, ticks with and without expiries,
    // the unused code, and disabled behavior.
    row_t table_rows[$];

    task automatic add_row(cmd_t c, bit has, result_t r);
        row_t row;
        row.cmd = c;
        row.has_exp = has;
        row.exp = r;
        table_rows.push_back(row);
    endtask

    initial
    begin
        int sent;
        cmd_t c;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        in_valid   = 1'b0;
        operation  = '0;
        period     = '0;
        repeat_req = 1'b0;
        key        = '0;
        user_tag   = '0;
        mismatches = 0;
        long_hold  = 0;
        wheel_on   = 0;
        wheel_now  = '0;
        row_has_exp = 1'b0;
        foreach (slot_busy[i]) slot_busy[i] = 0;
        dont_care = {KIND_EXPIRED, 5'h1f, 1'b0, 32'h0, 1'b0};
        row_exp   = dont_care;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: still disabled after reset; adds are turned away, ticks ignored.
        add_row(make_cmd(OP_ADD, 13'd5, 1'b1, 5'd0, 32'hffff_ffff), 1,
                make_result(KIND_ADD_FULL, 0, 1'b0, '0, 1'b0));
        add_row(make_cmd(OP_TICK, 13'd0, 1'b0, 5'd0, 32'h0), 0, dont_care);
        add_row(make_cmd(OP_STOP, 13'd0, 1'b0, 5'd31, 32'h0), 1,
                make_result(KIND_STOP, 31, 1'b0, '0, 1'b0));
        foreach (table_rows[i])
        begin
            row_has_exp = table_rows[i].has_exp;
            row_exp     = table_rows[i].exp;
            send_word(table_rows[i].cmd);
            row_has_exp = 1'b0;
        end
        table_rows.delete();

        write_enable(1'b1);

        // Phase 2: enabled. The first add lands in slot 0 with a zero period.
        add_row(make_cmd(OP_ADD, 13'd0, 1'b0, 5'd0, 32'h0000_0000), 1,
                make_result(KIND_ADD_OK, 0, 1'b0, '0, 1'b0));
        add_row(make_cmd(OP_ADD, 13'd8191, 1'b1, 5'd31, 32'hffff_ffff), 1,
                make_result(KIND_ADD_OK, 1, 1'b0, '0, 1'b0));
        add_row(make_cmd(OP_ADD, 13'd1, 1'b1, 5'd0, 32'ha5a5_5a5a), 1,
                make_result(KIND_ADD_OK, 2, 1'b0, '0, 1'b0));
        add_row(make_cmd(OP_TICK, 13'd8191, 1'b1, 5'd31, 32'hffff_ffff), 0, dont_care);
        add_row(make_cmd(OP_TICK, 13'd0, 1'b0, 5'd0, 32'h0), 0, dont_care);
        add_row(make_cmd(OP_TICK, 13'd0, 1'b0, 5'd0, 32'h0), 0, dont_care);
        add_row(make_cmd(OP_STOP, 13'd0, 1'b0, 5'd0, 32'h0), 1,
                make_result(KIND_STOP, 0, 1'b0, '0, 1'b0));
        add_row(make_cmd(OP_STOP, 13'd0, 1'b0, 5'd1, 32'h0), 1,
                make_result(KIND_STOP, 1, 1'b1, '0, 1'b0));
        add_row(make_cmd(OP_UNUSED, 13'd8191, 1'b1, 5'd31, 32'hffff_ffff), 0, dont_care);
        foreach (table_rows[i])
        begin
            row_has_exp = table_rows[i].has_exp;
            row_exp     = table_rows[i].exp;
            send_word(table_rows[i].cmd);
            row_has_exp = 1'b0;
        end
        table_rows.delete();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        typed_results.delete();

        // Fill the pool; the adds beyond the free slots must report the pool as full.
        for (int i = 0; i < NUM_TIMERS + 1; i++)
            send_word(make_cmd(OP_ADD, 13'($urandom_range(0, 3)), 1'($urandom), '0,
                               $urandom));
        // Several ticks expire the short timers in ascending key order.
        repeat (5) send_word(make_cmd(OP_TICK, '0, 1'b0, '0, '0));

        // Turning the wheel off clears everything; turn it back on and run random.
        write_enable(1'b0);
        write_enable(1'b1);

        // Ask the receiver for one long hold while the sender keeps pushing.
        long_hold = 1;
        sent = 0;
        while (sent < 48)
        begin
            c = random_cmd();
            send_word(c);
            if (c.operation == OP_TICK || c.operation == OP_ADD || c.operation == OP_STOP)
                sent++;
            if (sent == 30 && c.operation != OP_UNUSED)
            begin
                write_enable(1'b0);
                write_enable(1'b1);
            end
        end

        // A closing disabled phase: one add and one stop while off.
        write_enable(1'b0);
        send_word(make_cmd(OP_ADD, 13'd3, 1'b1, '0, $urandom));
        send_word(make_cmd(OP_STOP, '0, 1'b0, 5'd0, '0));
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_timing_wheel_timer_manager_top: done, clean");
        else
            $display("tb_timing_wheel_timer_manager_top: done, errors");
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #2ms;
        $display("tb_timing_wheel_timer_manager_top: done, errors");
        $finish;
    end
endmodule
